>>> rtl/core/fcc_pkg.sv
// Shared types and constants for the Freeman chain code tracer.
package fcc_pkg;

    localparam int MAX_WIDTH  = 256;
    localparam int MAX_HEIGHT = 256;
    localparam int PIX_DEPTH  = MAX_WIDTH * MAX_HEIGHT;
    localparam int PIX_AW     = $clog2(PIX_DEPTH);

    localparam int COORD_W = 8;
    localparam int SIZE_W  = 9;
    localparam int WORD_W  = 19;

    localparam logic [SIZE_W-1:0] MAX_WIDTH_V  = SIZE_W'(MAX_WIDTH);
    localparam logic [SIZE_W-1:0] MAX_HEIGHT_V = SIZE_W'(MAX_HEIGHT);
    localparam logic [WORD_W-1:0] WORD_MAX     = '1;
    localparam logic [7:0]        PIXEL_SET    = 8'd255;

    // neighbour offsets per direction, column then row
    localparam logic signed [1:0] STEP_COL [8] = '{2'sd1, 2'sd1, 2'sd0, -2'sd1,
                                                   -2'sd1, -2'sd1, 2'sd0, 2'sd1};
    localparam logic signed [1:0] STEP_ROW [8] = '{2'sd0, 2'sd1, 2'sd1, 2'sd1,
                                                   2'sd0, -2'sd1, -2'sd1, -2'sd1};

    typedef enum logic [1:0] {
        OP_LOAD    = 2'd0,
        OP_RESTART = 2'd1,
        OP_REQUEST = 2'd2
    } opcode_t;

    typedef enum logic [1:0] {
        KIND_START = 2'd0,
        KIND_DIR   = 2'd1,
        KIND_DONE  = 2'd2
    } kind_t;

    localparam logic [1:0] REG_WIDTH  = 2'd0;
    localparam logic [1:0] REG_HEIGHT = 2'd1;
    localparam logic [1:0] REG_EMIT   = 2'd2;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_DISPATCH,
        ST_SCAN,
        ST_PROBE
    } state_t;

endpackage

>>> rtl/core/fcc_ifs.sv
// Command and code channel interfaces of the chain code tracer.
interface fcc_cmd_if
    import fcc_pkg::*;
();
    logic              valid;
    logic              ready;
    logic [1:0]        opcode;
    logic [PIX_AW-1:0] pixel_address;
    logic [7:0]        pixel_value;

    modport source (output valid, output opcode, output pixel_address, output pixel_value,
                    input ready);
    modport sink   (input valid, input opcode, input pixel_address, input pixel_value,
                    output ready);
endinterface

interface fcc_code_if
    import fcc_pkg::*;
();
    logic               valid;
    logic               ready;
    logic [1:0]         code_kind;
    logic [COORD_W-1:0] start_column;
    logic [COORD_W-1:0] start_row;
    logic [2:0]         direction;
    logic [WORD_W-1:0]  words_emitted;

    modport source (output valid, output code_kind, output start_column, output start_row,
                    output direction, output words_emitted, input ready);
    modport sink   (input valid, input code_kind, input start_column, input start_row,
                    input direction, input words_emitted, output ready);
endinterface

>>> rtl/core/fcc_ram.sv
// Generic single-write, single-read RAM with registered read data.
module fcc_ram #(
    parameter int WIDTH = 1,
    parameter int DEPTH = 2
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;
endmodule

>>> rtl/core/freeman_chain_code_tracer.sv
// Top level of the 8-connected Freeman chain code tracer.
// - cmd channel (valid/ready): opcode LOAD writes one pixel bit (set when the value
//   is 255) at pixel_address; RESTART rewinds the scan and zeroes the word count;
//   REQUEST asks for the next code word. Unused opcodes are dropped.
// - code channel (valid/ready): one transfer per REQUEST: a chain start record
//   (column, row), a direction code, or scan finished; words_emitted is the running
//   word count (start record = 3 words, direction = 1), saturating.
// - APB port: image_width at 0x0, image_height at 0x4, emit_start_records at 0x8.
//   Write only while the block is idle.
// Reads: a REQUEST issues at most one pixel-memory read per cycle and sees its data
//   in the next cycle. Neighbours are probed in direction order, lowest first. With
//   start records off, a chain that dies at its start pixel is probed in all eight
//   directions before the scan resumes.
// The single-port-read pixel memory sets the rate: one probe or scan step a cycle.
// Reset: registers return to 256 x 256 with start records on, scan rewound. The
//   pixel memory is not cleared; pixels must be loaded before they are traced.
// Stall: the result sits in an output register; commands are still taken while it
//   waits, but a new REQUEST starts only once that register has drained.
module freeman_chain_code_tracer
    import fcc_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         psel,
    input  logic         penable,
    input  logic         pwrite,
    input  logic [3:0]   paddr,
    input  logic [31:0]  pwdata,
    output logic [31:0]  prdata,
    output logic         pready,
    fcc_cmd_if.sink      cmd,
    fcc_code_if.source   code
);

    // configuration
    logic [SIZE_W-1:0] image_width_reg, image_height_reg;
    logic              emit_start_reg;
    logic [SIZE_W-1:0] w_eff, h_eff;
    logic              cfg_write;

    // scan / trace state
    state_t             state_reg, state_next;
    logic [SIZE_W-1:0]  scan_col_reg, scan_col_next;
    logic [COORD_W-1:0] scan_row_reg, scan_row_next;
    logic [COORD_W-1:0] trace_col_reg, trace_col_next;
    logic [COORD_W-1:0] trace_row_reg, trace_row_next;
    logic               tracing_reg, tracing_next;
    logic               scan_done_reg, scan_done_next;
    logic [WORD_W-1:0]  word_count_reg, word_count_next;
    logic [3:0]         probe_dir_reg, probe_dir_next;

    // outstanding memory read
    logic               pend_valid_reg, pend_valid_next;
    logic [PIX_AW-1:0]  pend_addr_reg, pend_addr_next;
    logic [COORD_W-1:0] pend_col_reg, pend_col_next;
    logic [COORD_W-1:0] pend_row_reg, pend_row_next;
    logic [2:0]         pend_dir_reg, pend_dir_next;

    // output register
    logic               out_valid_reg, out_valid_next;
    logic [1:0]         out_kind_reg, out_kind_next;
    logic [COORD_W-1:0] out_col_reg, out_col_next;
    logic [COORD_W-1:0] out_row_reg, out_row_next;
    logic [2:0]         out_dir_reg, out_dir_next;
    logic [WORD_W-1:0]  out_words_reg, out_words_next;
    logic               load_out;

    // memory port
    logic              ram_we;
    logic [PIX_AW-1:0] ram_waddr;
    logic              ram_wdata;
    logic [PIX_AW-1:0] ram_raddr;
    logic              ram_rdata;

    logic cmd_xfer;
    logic hit;
    logic restart_xfer;

    // address arithmetic
    logic [COORD_W-1:0] addr_col, addr_row;
    logic [17:0]        addr_prod, addr_sum;
    logic [PIX_AW-1:0]  calc_addr;
    logic [2:0]         pdir;
    logic [1:0]         sc, sr;
    logic [9:0]         nc, nr;
    logic               nb_inbound;
    logic               scan_issue;
    logic [SIZE_W-1:0]  row_inc;

    function automatic logic [WORD_W-1:0] sat_add(input logic [WORD_W-1:0] a,
                                                  input logic [1:0] n);
        logic [WORD_W:0] s;
        s = {1'b0, a} + {{(WORD_W-1){1'b0}}, n};
        return s[WORD_W] ? WORD_MAX : s[WORD_W-1:0];
    endfunction

    //----------------------------------------------------------------------
    // APB registers
    //----------------------------------------------------------------------
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            image_width_reg  <= MAX_WIDTH_V;
            image_height_reg <= MAX_HEIGHT_V;
            emit_start_reg   <= 1'b1;
        end
        else if (cfg_write)
        begin
            case (paddr[3:2])
                REG_WIDTH:  image_width_reg  <= pwdata[SIZE_W-1:0];
                REG_HEIGHT: image_height_reg <= pwdata[SIZE_W-1:0];
                REG_EMIT:   emit_start_reg   <= pwdata[0];
                default:    ;
            endcase
        end
    end

    always_comb
    begin
        case (paddr[3:2])
            REG_WIDTH:  prdata = {{(32-SIZE_W){1'b0}}, image_width_reg};
            REG_HEIGHT: prdata = {{(32-SIZE_W){1'b0}}, image_height_reg};
            REG_EMIT:   prdata = {31'b0, emit_start_reg};
            default:    prdata = '0;
        endcase
    end

    // zero reads as one, oversize saturates
    always_comb
    begin
        if (image_width_reg == '0)
            w_eff = SIZE_W'(1);
        else if (image_width_reg > MAX_WIDTH_V)
            w_eff = MAX_WIDTH_V;
        else
            w_eff = image_width_reg;

        if (image_height_reg == '0)
            h_eff = SIZE_W'(1);
        else if (image_height_reg > MAX_HEIGHT_V)
            h_eff = MAX_HEIGHT_V;
        else
            h_eff = image_height_reg;
    end

    //----------------------------------------------------------------------
    // Pixel memory
    //----------------------------------------------------------------------
    fcc_ram #(
        .WIDTH (1),
        .DEPTH (PIX_DEPTH)
    ) u_pixel_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    //----------------------------------------------------------------------
    // Neighbor and scan addressing
    //----------------------------------------------------------------------
    assign pdir = probe_dir_reg[2:0];
    assign sc   = STEP_COL[pdir];
    assign sr   = STEP_ROW[pdir];
    assign nc   = {2'b00, trace_col_reg} + {{8{sc[1]}}, sc};
    assign nr   = {2'b00, trace_row_reg} + {{8{sr[1]}}, sr};
    assign nb_inbound = !nc[9] && !nr[9] && (nc[8:0] < w_eff) && (nr[8:0] < h_eff);

    assign scan_issue = (scan_col_reg < w_eff) && ({1'b0, scan_row_reg} < h_eff);
    assign row_inc    = {1'b0, scan_row_reg} + SIZE_W'(1);

    always_comb
    begin
        if (state_reg == ST_PROBE)
        begin
            addr_col = nc[COORD_W-1:0];
            addr_row = nr[COORD_W-1:0];
        end
        else
        begin
            addr_col = scan_col_reg[COORD_W-1:0];
            addr_row = scan_row_reg;
        end
    end

    // row * width + column, one multiplier shared by scan and probe
    assign addr_prod = {10'b0, addr_row} * {9'b0, w_eff};
    assign addr_sum  = addr_prod + {10'b0, addr_col};
    assign calc_addr = addr_sum[PIX_AW-1:0];
    assign ram_raddr = calc_addr;

    // previous read came back set
    assign hit = pend_valid_reg && ram_rdata;

    //----------------------------------------------------------------------
    // Handshakes
    //----------------------------------------------------------------------
    assign cmd.ready    = (state_reg == ST_IDLE);
    assign cmd_xfer     = cmd.valid && cmd.ready;
    assign restart_xfer = cmd_xfer && (opcode_t'(cmd.opcode) == OP_RESTART);

    assign code.valid         = out_valid_reg;
    assign code.code_kind     = out_kind_reg;
    assign code.start_column  = out_col_reg;
    assign code.start_row     = out_row_reg;
    assign code.direction     = out_dir_reg;
    assign code.words_emitted = out_words_reg;

    //----------------------------------------------------------------------
    // Next state
    //----------------------------------------------------------------------
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (cmd_xfer && (opcode_t'(cmd.opcode) == OP_REQUEST))
                    state_next = ST_DISPATCH;
            end
            ST_DISPATCH:
            begin
                // wait for the output register to drain
                if (!out_valid_reg)
                begin
                    if (scan_done_reg)
                        state_next = ST_IDLE;
                    else if (tracing_reg)
                        state_next = ST_PROBE;
                    else
                        state_next = ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                if (hit)
                    state_next = emit_start_reg ? ST_IDLE : ST_PROBE;
                else if (scan_col_reg >= w_eff)
                    state_next = ST_IDLE;
            end
            ST_PROBE:
            begin
                if (hit)
                    state_next = ST_IDLE;
                else if (probe_dir_reg[3])
                    state_next = ST_SCAN;
            end
            default: state_next = ST_IDLE;
        endcase
    end

    //----------------------------------------------------------------------
    // Datapath and memory control
    //----------------------------------------------------------------------
    always_comb
    begin
        scan_col_next   = scan_col_reg;
        scan_row_next   = scan_row_reg;
        trace_col_next  = trace_col_reg;
        trace_row_next  = trace_row_reg;
        tracing_next    = tracing_reg;
        scan_done_next  = scan_done_reg;
        word_count_next = word_count_reg;
        probe_dir_next  = probe_dir_reg;
        pend_valid_next = 1'b0;
        pend_addr_next  = pend_addr_reg;
        pend_col_next   = pend_col_reg;
        pend_row_next   = pend_row_reg;
        pend_dir_next   = pend_dir_reg;
        load_out        = 1'b0;
        out_kind_next   = KIND_DONE;
        out_col_next    = '0;
        out_row_next    = '0;
        out_dir_next    = '0;
        out_words_next  = word_count_reg;
        ram_we          = 1'b0;
        ram_waddr       = pend_addr_reg;
        ram_wdata       = 1'b0;

        case (state_reg)
            ST_IDLE:
            begin
                if (cmd_xfer)
                begin
                    case (opcode_t'(cmd.opcode))
                        OP_LOAD:
                        begin
                            ram_we    = 1'b1;
                            ram_waddr = cmd.pixel_address;
                            ram_wdata = (cmd.pixel_value == PIXEL_SET);
                        end
                        OP_RESTART:
                        begin
                            scan_col_next   = '0;
                            scan_row_next   = '0;
                            trace_col_next  = '0;
                            trace_row_next  = '0;
                            tracing_next    = 1'b0;
                            scan_done_next  = 1'b0;
                            word_count_next = '0;
                        end
                        default: ;
                    endcase
                end
            end
            ST_DISPATCH:
            begin
                probe_dir_next = '0;
                if (!out_valid_reg && scan_done_reg)
                begin
                    load_out      = 1'b1;
                    out_kind_next = KIND_DONE;
                end
            end
            ST_SCAN:
            begin
                if (hit)
                begin
                    // chain start: clear it, park the scan on it
                    ram_we         = 1'b1;
                    scan_col_next  = {1'b0, pend_col_reg};
                    scan_row_next  = pend_row_reg;
                    trace_col_next = pend_col_reg;
                    trace_row_next = pend_row_reg;
                    tracing_next   = 1'b1;
                    probe_dir_next = '0;
                    if (emit_start_reg)
                    begin
                        word_count_next = sat_add(word_count_reg, 2'd3);
                        load_out        = 1'b1;
                        out_kind_next   = KIND_START;
                        out_col_next    = pend_col_reg;
                        out_row_next    = pend_row_reg;
                        out_words_next  = sat_add(word_count_reg, 2'd3);
                    end
                end
                else if (scan_col_reg >= w_eff)
                begin
                    scan_done_next = 1'b1;
                    load_out       = 1'b1;
                    out_kind_next  = KIND_DONE;
                end
                else if (!scan_issue)
                begin
                    // row past a shrunken height: next column
                    scan_row_next = '0;
                    scan_col_next = scan_col_reg + SIZE_W'(1);
                end
                else
                begin
                    pend_valid_next = 1'b1;
                    pend_addr_next  = calc_addr;
                    pend_col_next   = scan_col_reg[COORD_W-1:0];
                    pend_row_next   = scan_row_reg;
                    if (row_inc >= h_eff)
                    begin
                        scan_row_next = '0;
                        scan_col_next = scan_col_reg + SIZE_W'(1);
                    end
                    else
                    begin
                        scan_row_next = row_inc[COORD_W-1:0];
                    end
                end
            end
            ST_PROBE:
            begin
                if (hit)
                begin
                    ram_we          = 1'b1;
                    trace_col_next  = pend_col_reg;
                    trace_row_next  = pend_row_reg;
                    word_count_next = sat_add(word_count_reg, 2'd1);
                    load_out        = 1'b1;
                    out_kind_next   = KIND_DIR;
                    out_dir_next    = pend_dir_reg;
                    out_words_next  = sat_add(word_count_reg, 2'd1);
                end
                else if (probe_dir_reg[3])
                begin
                    // dead end: chain over, resume the scan
                    tracing_next = 1'b0;
                end
                else
                begin
                    pend_valid_next = nb_inbound;
                    pend_addr_next  = calc_addr;
                    pend_col_next   = nc[COORD_W-1:0];
                    pend_row_next   = nr[COORD_W-1:0];
                    pend_dir_next   = pdir;
                    probe_dir_next  = probe_dir_reg + 4'd1;
                end
            end
            default: ;
        endcase

        out_valid_next = load_out || (out_valid_reg && !code.ready);
    end

    //----------------------------------------------------------------------
    // Registers
    //----------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            scan_col_reg   <= '0;
            scan_row_reg   <= '0;
            trace_col_reg  <= '0;
            trace_row_reg  <= '0;
            tracing_reg    <= 1'b0;
            scan_done_reg  <= 1'b0;
            word_count_reg <= '0;
            probe_dir_reg  <= '0;
            pend_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            scan_col_reg   <= scan_col_next;
            scan_row_reg   <= scan_row_next;
            trace_col_reg  <= trace_col_next;
            trace_row_reg  <= trace_row_next;
            tracing_reg    <= tracing_next;
            scan_done_reg  <= scan_done_next;
            word_count_reg <= word_count_next;
            probe_dir_reg  <= probe_dir_next;
            pend_valid_reg <= pend_valid_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pend_addr_reg <= pend_addr_next;
        pend_col_reg  <= pend_col_next;
        pend_row_reg  <= pend_row_next;
        pend_dir_reg  <= pend_dir_next;
        if (load_out)
        begin
            out_kind_reg  <= out_kind_next;
            out_col_reg   <= out_col_next;
            out_row_reg   <= out_row_next;
            out_dir_reg   <= out_dir_next;
            out_words_reg <= out_words_next;
        end
    end

    //----------------------------------------------------------------------
    // Assertions
    //----------------------------------------------------------------------
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        load_out |-> !out_valid_reg)
        else $error("result loaded over an undelivered one");

    a_probe_needs_chain: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_PROBE) |-> tracing_reg)
        else $error("probing without an active chain");

    a_done_not_tracing: assert property (@(posedge clk) disable iff (!rst_n)
        scan_done_reg |-> !tracing_reg)
        else $error("scan finished while a chain is open");

    a_pend_origin: assert property (@(posedge clk) disable iff (!rst_n)
        pend_valid_reg |-> ($past(state_reg) == ST_SCAN || $past(state_reg) == ST_PROBE))
        else $error("read pending outside scan or probe");

    a_count_monotone: assert property (@(posedge clk) disable iff (!rst_n)
        !restart_xfer |=> (word_count_reg >= $past(word_count_reg)))
        else $error("word count decreased without a restart");

endmodule

>>> tb/fcc_tracker_pkg.sv
// Chain code tracker: predicts and checks the tracer's code words.
package fcc_tracker_pkg;
    import fcc_pkg::*;

    localparam logic [1:0] OP_UNUSED = 2'd3;

    // neighbour offsets per direction, east first, counter-clockwise
    localparam int HOP_COL [8] = '{1, 1, 0, -1, -1, -1, 0, 1};
    localparam int HOP_ROW [8] = '{0, 1, 1, 1, 0, -1, -1, -1};

    typedef struct packed {
        kind_t              kind;
        logic [COORD_W-1:0] column;
        logic [COORD_W-1:0] row;
        logic [2:0]         direction;
        logic [WORD_W-1:0]  words;
    } code_word_t;

    class chain_code_tracker;
        bit          pixels [PIX_DEPTH];
        int unsigned width_reg;
        int unsigned height_reg;
        bit          emit_starts;
        int unsigned scan_col;
        int unsigned scan_row;
        int unsigned trace_col;
        int unsigned trace_row;
        bit          tracing;
        bit          finished;
        int unsigned word_count;
        code_word_t  codes_due [$];
        int unsigned errors;
        int unsigned starts_seen;
        int unsigned dirs_seen;
        int unsigned dones_seen;

        function new();
            width_reg   = MAX_WIDTH;
            height_reg  = MAX_HEIGHT;
            emit_starts = 1'b1;
            scan_col    = 0;
            scan_row    = 0;
            trace_col   = 0;
            trace_row   = 0;
            tracing     = 1'b0;
            finished    = 1'b0;
            word_count  = 0;
            errors      = 0;
            starts_seen = 0;
            dirs_seen   = 0;
            dones_seen  = 0;
        endfunction

        function int unsigned cols_in_use();
            if (width_reg == 0)
                return 1;
            return (width_reg > MAX_WIDTH) ? MAX_WIDTH : width_reg;
        endfunction

        function int unsigned rows_in_use();
            if (height_reg == 0)
                return 1;
            return (height_reg > MAX_HEIGHT) ? MAX_HEIGHT : height_reg;
        endfunction

        function void set_register(logic [1:0] idx, logic [31:0] value);
            case (idx)
                REG_WIDTH:  width_reg   = value[8:0];
                REG_HEIGHT: height_reg  = value[8:0];
                REG_EMIT:   emit_starts = value[0];
                default: ;
            endcase
        endfunction

        function logic [31:0] register_value(logic [1:0] idx);
            case (idx)
                REG_WIDTH:  return width_reg;
                REG_HEIGHT: return height_reg;
                REG_EMIT:   return {31'd0, emit_starts};
                default:    return '0;
            endcase
        endfunction

        function void add_words(int unsigned n);
            word_count = (word_count + n > WORD_MAX) ? WORD_MAX : word_count + n;
        endfunction

        // move to the first set neighbour of the trace pixel, clearing it
        function bit step_along(output logic [2:0] dir);
            int unsigned w;
            int unsigned h;
            int unsigned a;
            int          nc;
            int          nr;
            int          d;
            w   = cols_in_use();
            h   = rows_in_use();
            dir = '0;
            for (d = 0; d < 8; d++) begin
                nc = int'(trace_col) + HOP_COL[d];
                nr = int'(trace_row) + HOP_ROW[d];
                if (nc >= 0 && nr >= 0 && nc < int'(w) && nr < int'(h)) begin
                    a = unsigned'(nr) * w + unsigned'(nc);
                    if (pixels[a]) begin
                        pixels[a] = 1'b0;
                        trace_col = unsigned'(nc);
                        trace_row = unsigned'(nr);
                        dir       = d[2:0];
                        return 1'b1;
                    end
                end
            end
            return 1'b0;
        endfunction

        function void serve_request();
            code_word_t  word;
            logic [2:0]  dir;
            int unsigned w;
            int unsigned h;
            int unsigned a;
            bit          found;
            while (1) begin
                word = '0;
                if (finished) begin
                    word.kind  = KIND_DONE;
                    word.words = word_count[WORD_W-1:0];
                    codes_due.push_back(word);
                    return;
                end
                if (tracing) begin
                    if (step_along(dir)) begin
                        add_words(1);
                        word.kind      = KIND_DIR;
                        word.direction = dir;
                        word.words     = word_count[WORD_W-1:0];
                        codes_due.push_back(word);
                        return;
                    end
                    tracing = 1'b0;
                end
                w     = cols_in_use();
                h     = rows_in_use();
                found = 1'b0;
                while (!found && scan_col < w) begin
                    while (scan_row < h) begin
                        a = scan_row * w + scan_col;
                        if (pixels[a]) begin
                            pixels[a] = 1'b0;
                            found     = 1'b1;
                            break;
                        end
                        scan_row++;
                    end
                    if (!found) begin
                        scan_row = 0;
                        scan_col++;
                    end
                end
                if (!found) begin
                    finished = 1'b1;
                    continue;
                end
                trace_col = scan_col;
                trace_row = scan_row;
                tracing   = 1'b1;
                if (emit_starts) begin
                    add_words(3);
                    word.kind   = KIND_START;
                    word.column = scan_col[7:0];
                    word.row    = scan_row[7:0];
                    word.words  = word_count[WORD_W-1:0];
                    codes_due.push_back(word);
                    return;
                end
            end
        endfunction

        function void take_command(logic [1:0] op, logic [PIX_AW-1:0] addr, logic [7:0] value);
            case (op)
                OP_LOAD: pixels[addr] = (value == PIXEL_SET);
                OP_RESTART: begin
                    scan_col   = 0;
                    scan_row   = 0;
                    trace_col  = 0;
                    trace_row  = 0;
                    tracing    = 1'b0;
                    finished   = 1'b0;
                    word_count = 0;
                end
                OP_REQUEST: serve_request();
                default: ;
            endcase
        endfunction

        function void compare_field(string name, logic [31:0] want, logic [31:0] got);
            if (got !== want) begin
                errors++;
                $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
            end
        endfunction

        function void match_code(code_word_t got);
            code_word_t want;
            if (codes_due.size() == 0) begin
                errors++;
                $display("%0t: unexpected code word, expected none, actual kind %0d words %0d",
                         $time, got.kind, got.words);
                return;
            end
            want = codes_due.pop_front();
            case (want.kind)
                KIND_START: starts_seen++;
                KIND_DIR:   dirs_seen++;
                default:    dones_seen++;
            endcase
            compare_field("code_kind", want.kind, got.kind);
            compare_field("start_column", want.column, got.column);
            compare_field("start_row", want.row, got.row);
            compare_field("direction", want.direction, got.direction);
            compare_field("words_emitted", want.words, got.words);
        endfunction
    endclass

endpackage

>>> tb/tb_freeman_chain_code_tracer.sv
// Self-checking testbench for the Freeman chain code tracer.
module tb_freeman_chain_code_tracer;
    import fcc_pkg::*;
    import fcc_tracker_pkg::*;

    localparam int ITEM_TARGET   = 1800;
    // worst quiet stretch: one request over a 256-pixel strip of isolated pixels
    // with start records off, plus a receiver stall
    localparam int IDLE_LIMIT    = 20000;
    // margin before a register write; the block is idle once its last code word drained
    localparam int SETTLE_CYCLES = 16;

    logic        clk;
    logic        rst_n;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [3:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    fcc_cmd_if  cmd ();
    fcc_code_if code ();

    freeman_chain_code_tracer dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cmd     (cmd),
        .code    (code)
    );

    chain_code_tracker tracker;
    code_word_t        seen_code;
    bit                loaded [PIX_DEPTH];   // pixels the block has been given at least once
    int                burst_left;
    int unsigned       items_sent;
    int unsigned       phases;
    int unsigned       quiet_cycles;

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    // ------------------------------------------------------------------
    // Command side. Inputs change on the falling edge; a transfer is taken
    // at the rising edge where valid and ready are both high, and the
    // tracker is updated right there, so its state is current by the next
    // falling edge when the next command is chosen.
    // ------------------------------------------------------------------
    task automatic send_command(input logic [1:0] op, input logic [PIX_AW-1:0] addr,
                                input logic [7:0] value);
        int gap;
        @(negedge clk);
        if (burst_left <= 0)
        begin
            // new burst; now and then a long run with no gaps at all
            burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(60, 120)
                                                      : $urandom_range(1, 16);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
            if (gap > 0)
            begin
                cmd.valid <= 1'b0;
                repeat (gap) @(negedge clk);
            end
        end
        burst_left--;
        cmd.valid         <= 1'b1;
        cmd.opcode        <= op;
        cmd.pixel_address <= addr;
        cmd.pixel_value   <= value;
        do @(posedge clk); while (!cmd.ready);
        tracker.take_command(op, addr, value);
        if (op == OP_LOAD)
            loaded[addr] = 1'b1;
        if (op != OP_UNUSED)
            items_sent++;
    endtask

    // request with junk in the unused fields
    task automatic ask_code();
        send_command(OP_REQUEST, PIX_AW'($urandom), 8'($urandom));
    endtask

    function automatic logic [7:0] pick_pixel(int unsigned density);
        if ($urandom_range(1, 100) <= density)
            return PIXEL_SET;
        return 8'($urandom_range(0, 254));
    endfunction

    // Sender holds off until every expected code word has come back, then
    // lets the block settle. Used after each directed test and each phase,
    // before the next register writes, and once more at the end of the run.
    task automatic drain_codes();
        @(negedge clk);
        cmd.valid <= 1'b0;
        burst_left = 0;
        while (tracker.codes_due.size() != 0) @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    // APB write (setup + access), then a read-back of the same register
    task automatic write_register(input logic [1:0] idx, input logic [31:0] value);
        logic [31:0] readback;
        @(negedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(negedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        tracker.set_register(idx, value);
        @(negedge clk);
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(negedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        readback = prdata;
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        if (readback !== tracker.register_value(idx))
        begin
            tracker.errors++;
            $display("%0t: register %0d readback mismatch, expected %0d, actual %0d",
                     $time, idx, tracker.register_value(idx), readback);
        end
    endtask

    // The pixel store powers up undefined, so every pixel the scan can reach
    // under the current sizes gets loaded once before any request.
    task automatic cover_region(input int unsigned n);
        int unsigned a;
        for (a = 0; a < n; a++)
            if (!loaded[a])
                send_command(OP_LOAD, PIX_AW'(a), pick_pixel(30));
    endtask

    // Request until the scan reports finished, then a few more to see the
    // finished word repeat. Optionally drops fresh pixels in along the way.
    task automatic finish_scan(input int unsigned extra, input bit sprinkle,
                               input int unsigned n);
        int unsigned guard;
        guard = 0;
        while (!tracker.finished && guard < 1000)
        begin
            if (sprinkle && $urandom_range(0, 5) == 0)
                send_command(OP_LOAD, PIX_AW'($urandom_range(0, n - 1)), pick_pixel(50));
            ask_code();
            guard++;
        end
        repeat (extra) ask_code();
    endtask

    // ------------------------------------------------------------------
    // One random phase: new register settings while idle, then one of
    //   - full image load, restart, trace (most phases)
    //   - scattered loads over the whole store, restart, trace with loads
    //     mixed in (forced for the long thin strips)
    //   - carry on the old scan under the new sizes (no restart)
    //   - pure noise: any opcode, unused one included
    // ------------------------------------------------------------------
    task automatic run_phase();
        int unsigned pick;
        int unsigned w_raw;
        int unsigned h_raw;
        int unsigned n;
        int unsigned mode;
        int unsigned a;
        int unsigned k;
        int unsigned density;

        pick = (phases < 2) ? phases : $urandom_range(0, 19);
        if (pick == 0)
        begin
            // width at or past the maximum saturates, height zero counts as one row
            w_raw = (phases == 0) ? 511 : $urandom_range(256, 511);
            h_raw = (phases == 0) ? 0 : $urandom_range(0, 1);
        end
        else if (pick == 1)
        begin
            w_raw = (phases == 1) ? 0 : $urandom_range(0, 1);
            h_raw = (phases == 1) ? 256 : $urandom_range(256, 511);
        end
        else if (pick < 5)
        begin
            w_raw = $urandom_range(1, 3);
            h_raw = $urandom_range(1, 3);
        end
        else
        begin
            w_raw = $urandom_range(2, 12);
            h_raw = $urandom_range(2, 12);
        end

        // now and then only the start-record switch changes
        if ($urandom_range(0, 4) != 0 || pick < 2)
        begin
            write_register(REG_WIDTH, w_raw);
            write_register(REG_HEIGHT, h_raw);
        end
        write_register(REG_EMIT, ($urandom_range(0, 3) != 0) ? 32'd1 : 32'd0);

        n = tracker.cols_in_use() * tracker.rows_in_use();
        mode = (n > 150) ? 5 : $urandom_range(0, 7);
        cover_region(n);

        case (mode)
            5:
            begin
                k = $urandom_range(8, 30);
                repeat (k)
                begin
                    a = ($urandom_range(0, 1) == 1) ? $urandom_range(0, n - 1)
                                                    : $urandom_range(0, 65535);
                    send_command(OP_LOAD, PIX_AW'(a), pick_pixel(60));
                end
                // last pixel of the region: far end of a thin strip
                send_command(OP_LOAD, PIX_AW'(n - 1), PIXEL_SET);
                if ($urandom_range(0, 3) == 0)
                    send_command(OP_UNUSED, PIX_AW'($urandom), 8'($urandom));
                send_command(OP_RESTART, PIX_AW'($urandom), 8'($urandom));
                finish_scan($urandom_range(1, 2), 1'b1, n);
            end
            6:
            begin
                // scan position and trace carry over from the previous sizes
                k = $urandom_range(1, 8);
                repeat (k) ask_code();
            end
            7:
            begin
                repeat (20)
                begin
                    k = $urandom_range(0, 7);
                    if (k < 3)
                        send_command(OP_LOAD, PIX_AW'($urandom_range(0, 65535)), pick_pixel(35));
                    else if (k == 3)
                        send_command(OP_RESTART, PIX_AW'($urandom), 8'($urandom));
                    else if (k < 7)
                        ask_code();
                    else
                        send_command(OP_UNUSED, PIX_AW'($urandom), 8'($urandom));
                end
            end
            default:
            begin
                density = $urandom_range(15, 75);
                for (a = 0; a < n; a++)
                    send_command(OP_LOAD, PIX_AW'(a), pick_pixel(density));
                send_command(OP_RESTART, PIX_AW'($urandom), 8'($urandom));
                // usually run to the end; otherwise leave the scan mid-way
                // so a later phase changes sizes under a live scan
                if ($urandom_range(0, 2) != 0)
                    finish_scan($urandom_range(1, 3), 1'b0, n);
                else
                begin
                    k = $urandom_range(1, n / 2 + 1);
                    repeat (k) ask_code();
                end
            end
        endcase

        drain_codes();
        phases++;
    endtask

    // ------------------------------------------------------------------
    // Receiver: ready follows its own pattern, switching style every so
    // often between always ready, coin flip, mostly stalled and periodic.
    // ------------------------------------------------------------------
    initial
    begin : code_sink
        int unsigned style;
        int unsigned span;
        int unsigned i;
        code.ready = 1'b0;
        forever
        begin
            style = $urandom_range(0, 3);
            span  = $urandom_range(20, 200);
            for (i = 0; i < span; i++)
            begin
                @(negedge clk);
                case (style)
                    0:       code.ready <= 1'b1;
                    1:       code.ready <= ($urandom_range(0, 1) == 1);
                    2:       code.ready <= ($urandom_range(0, 3) == 0);
                    default: code.ready <= ((i % 9) < 5);
                endcase
            end
        end
    end

    // Result monitor: each code word transfer is checked against the oldest
    // prediction.
    always @(posedge clk)
    begin
        if (rst_n && code.valid && code.ready)
        begin
            seen_code.kind      = kind_t'(code.code_kind);
            seen_code.column    = code.start_column;
            seen_code.row       = code.start_row;
            seen_code.direction = code.direction;
            seen_code.words     = code.words_emitted;
            tracker.match_code(seen_code);
        end
    end

    // Watchdog: too long without any transfer or register access means a hang.
    always @(posedge clk)
    begin
        if (!rst_n || (cmd.valid && cmd.ready) || (code.valid && code.ready) || psel)
            quiet_cycles <= 0;
        else if (quiet_cycles >= IDLE_LIMIT)
        begin
            $display("%0t: no transfer for %0d cycles", $time, quiet_cycles);
            $display("FAILURE");
            $finish;
        end
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    initial
    begin
        tracker    = new();
        burst_left = 0;
        items_sent = 0;
        phases     = 0;
        rst_n      = 1'b0;
        psel       = 1'b0;
        penable    = 1'b0;
        pwrite     = 1'b0;
        paddr      = '0;
        pwdata     = '0;
        cmd.valid         = 1'b0;
        cmd.opcode        = OP_LOAD;
        cmd.pixel_address = '0;
        cmd.pixel_value   = '0;
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Directed: 3x3 image with two chains, other raw values including 254 so only
        // exact 255 counts as set, then requests past the end of the scan.
        write_register(REG_WIDTH, 32'd3);
        write_register(REG_HEIGHT, 32'd3);
        write_register(REG_EMIT, 32'd1);
        send_command(OP_LOAD, 16'd0, 8'd255);
        send_command(OP_LOAD, 16'd1, 8'd0);
        send_command(OP_LOAD, 16'd2, 8'd255);
        send_command(OP_LOAD, 16'd3, 8'd254);
        send_command(OP_LOAD, 16'd4, 8'd255);
        send_command(OP_LOAD, 16'd5, 8'd127);
        send_command(OP_LOAD, 16'd6, 8'd1);
        send_command(OP_LOAD, 16'd7, 8'd128);
        send_command(OP_LOAD, 16'd8, 8'd255);
        send_command(OP_RESTART, 16'd0, 8'd0);
        repeat (7) ask_code();
        // unused opcode with every field bit high: dropped, no code word
        send_command(OP_UNUSED, 16'hFFFF, 8'hFF);
        drain_codes();

        // Start records off, two isolated pixels: both swallowed silently
        // inside a single request that then reports the scan finished.
        write_register(REG_EMIT, 32'd0);
        send_command(OP_LOAD, 16'd0, 8'd255);
        send_command(OP_LOAD, 16'd8, 8'd255);
        send_command(OP_RESTART, 16'd0, 8'd0);
        repeat (2) ask_code();
        drain_codes();

        while (items_sent < ITEM_TARGET)
            run_phase();

        // all commands taken; drain_codes waits out the last code words
        drain_codes();
        repeat (20) @(posedge clk);

        $display("Ran %0d commands over %0d register settings, incl. saturated and zero sizes.",
                 items_sent, phases + 2);
        $display("Checked %0d start records, %0d direction codes, %0d scan-finished words; %0d errors.",
                 tracker.starts_seen, tracker.dirs_seen, tracker.dones_seen, tracker.errors);
        if (tracker.errors == 0 && tracker.codes_due.size() == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule

>>> filelist.f
rtl/core/fcc_pkg.sv
rtl/core/fcc_ifs.sv
rtl/core/fcc_ram.sv
rtl/core/freeman_chain_code_tracer.sv
tb/fcc_tracker_pkg.sv
tb/tb_freeman_chain_code_tracer.sv
